// ----- src/slr_pkg.sv -----
// shared types and constants for the sleep lease registry
// no dependencies
package slr_pkg;
  localparam int SLOTS = 32;
  localparam int KINDS = 12;
  localparam int TIME_BITS = 48;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = 6;

  localparam logic [2:0] OP_ACQUIRE = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_TRY_Q   = 3'd2;
  localparam logic [2:0] OP_EMERG_Q = 3'd3;
  localparam logic [2:0] OP_CANCEL_Q = 3'd4;
  localparam logic [2:0] OP_SCAN    = 3'd5;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_BAD_ARG    = 4'd1;
  localparam logic [3:0] ST_QUIESCING  = 4'd2;
  localparam logic [3:0] ST_FULL       = 4'd3;
  localparam logic [3:0] ST_STALE      = 4'd4;
  localparam logic [3:0] ST_UNDERFLOW  = 4'd5;
  localparam logic [3:0] ST_NOT_START  = 4'd6;
  localparam logic [3:0] ST_CANCEL_IGN = 4'd7;
  localparam logic [3:0] ST_WARNING    = 4'd8;
  localparam logic [3:0] ST_NO_WARN    = 4'd9;

  localparam logic [1:0] LOCK_NONE = 2'd0;
  localparam logic [1:0] LOCK_TAKE = 2'd1;
  localparam logic [1:0] LOCK_DROP = 2'd2;

  localparam logic [0:0] REG_WARN_AFTER = 1'd0;
  localparam logic [0:0] REG_EXEMPT     = 1'd1;

  // one lease record handed along the chain
  typedef struct packed {
    logic                 active;
    logic                 warned;
    logic [31:0]          id;
    logic [3:0]           kind;
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS-1:0] last_warn;
  } lease_t;
endpackage

// ----- src/slr_cell.sv -----
// one lease cell of the rotating chain: holds a record and passes it on
// depends on slr_pkg
module slr_cell
  import slr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  lease_t din,
  output lease_t dout
);
  lease_t rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.active <= 1'b0;
      rec.warned <= 1'b0;
    end else if (shift) begin
      rec.active <= din.active;
      rec.warned <= din.warned;
    end
    if (shift) begin
      rec.id        <= din.id;
      rec.kind      <= din.kind;
      rec.start     <= din.start;
      rec.last_warn <= din.last_warn;
    end
  end

  assign dout = rec;
endmodule

// ----- src/sleep_lease_registry.sv -----
// sleep lease registry top level: lease cell ring, control and apb registers
// depends on slr_pkg and slr_cell
// an item is latched in idle; the walk turns the ring once through every cell, held
// while a staged warning cannot leave; fin settles counters, out loads the result word
// a new item is taken only in idle; a warning word leaves when the next one is found
// reset clears all leases, counters and quiesce state; warn_after 0, exempt kind 11
module sleep_lease_registry
  import slr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           opcode,
  input  logic [3:0]           blocker_id,
  input  logic [5:0]           slot_index,
  input  logic [31:0]          lease_tag,
  input  logic [31:0]          generation_tag,
  input  logic [47:0]          now_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           status,
  output logic [4:0]           result_slot,
  output logic [31:0]          granted_id,
  output logic [5:0]           total_count,
  output logic [5:0]           kind_count,
  output logic                 quiescing,
  output logic [31:0]          current_generation,
  output logic [1:0]           sleep_lock_change,
  output logic [3:0]           warn_blocker,
  output logic [47:0]          held_time,
  output logic                 last
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [47:0] warn_after;
  logic [3:0]  exempt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      warn_after <= '0;
      exempt <= 4'd11;
    end else if (wr_en) begin
      if (paddr == {REG_WARN_AFTER, 3'b000}) warn_after <= pwdata[47:0];
      else if (paddr == {REG_EXEMPT, 3'b000}) exempt <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == {REG_WARN_AFTER, 3'b000}) prdata = {16'd0, warn_after};
    else if (paddr == {REG_EXEMPT, 3'b000}) prdata = {60'd0, exempt};
  end

  // latched item
  logic [2:0]  op;
  logic [3:0]  kind;
  logic [5:0]  sidx;
  logic [31:0] tag;
  logic [31:0] gen;
  logic [TIME_BITS-1:0] now;

  logic [31:0] next_id;
  logic [CNT_W-1:0] kcnt [KINDS];
  logic [CNT_W-1:0] total;
  logic        qflag;
  logic [31:0] qgen;

  logic [SLOT_W:0] step;
  logic        done;       // acquire placed or release handled
  logic [4:0]  grant_slot;
  logic [31:0] grant_id;
  logic        any_warn;   // a warning waits in the staging register

  // staged warning, sent once the next one is found or the walk ends
  logic [4:0]           w_slot;
  logic [3:0]           w_kind;
  logic [TIME_BITS-1:0] w_held;

  // settled result of the item
  logic [3:0]  r_status;
  logic [4:0]  r_slot;
  logic [31:0] r_gid;
  logic [1:0]  r_lock;

  // ring of cells; the head record is modified before entering the tail
  // the head's slot number is the step count, since the ring turns once per item
  lease_t ring [SLOTS+1];
  lease_t head, head_mod;
  logic   shift;

  assign head = ring[SLOTS];
  assign ring[0] = head_mod;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      slr_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .din  (ring[g]),
        .dout (ring[g+1])
      );
    end
  endgenerate

  // result word register
  logic        ov;
  logic [3:0]  o_status;
  logic [4:0]  o_slot;
  logic [31:0] o_gid;
  logic [5:0]  o_total, o_kcnt;
  logic        o_q;
  logic [31:0] o_gen;
  logic [1:0]  o_lock;
  logic [3:0]  o_wkind;
  logic [47:0] o_held;
  logic        o_last;

  logic out_free;
  assign out_free = !ov || !out_stall;

  // per-head evaluation
  logic [TIME_BITS-1:0] held, since;
  logic due, acq_hit, rel_hit, kvalid;
  always_comb begin
    kvalid = kind < 4'(KINDS);
    held = now - head.start;
    since = now - head.last_warn;
    due = head.active && head.kind != exempt && now >= head.start &&
          held >= warn_after &&
          (!head.warned || (now >= head.last_warn && since >= warn_after));
    acq_hit = op == OP_ACQUIRE && kvalid && !qflag && !done && !head.active;
    rel_hit = op == OP_RELEASE && step == sidx && head.active &&
              head.id == tag && head.kind == kind;
  end

  logic [31:0] id_a, id_use;
  always_comb begin
    id_use = next_id;
    if (id_use == 32'd0) id_use = 32'd1;
    id_a = id_use + 32'd1;
  end

  logic scan_emit;
  assign scan_emit = state == S_WALK && op == OP_SCAN && warn_after != '0 && due;

  // the ring holds while a staged warning must leave and has no room to do so
  assign shift = state == S_WALK && (!(scan_emit && any_warn) || out_free);

  logic push_warn, push_final;
  assign push_warn = scan_emit && any_warn && out_free;
  assign push_final = state == S_OUT && out_free;

  always_comb begin
    head_mod = head;
    if (state == S_WALK) begin
      if (acq_hit) begin
        head_mod.active = 1'b1;
        head_mod.warned = 1'b0;
        head_mod.id = id_use;
        head_mod.kind = kind;
        head_mod.start = now;
        head_mod.last_warn = '0;
      end else if (rel_hit) begin
        head_mod.active = 1'b0;
        head_mod.warned = 1'b0;
      end else if (scan_emit) begin
        head_mod.warned = 1'b1;
        head_mod.last_warn = now;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_WALK;
      S_WALK: if (shift && step == (SLOT_W+1)'(SLOTS-1)) state_next = S_FIN;
      S_FIN:  state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = state != S_IDLE;

  logic walk_ops;
  always_comb
    walk_ops = (op == OP_ACQUIRE && kvalid && !qflag) ||
               (op == OP_RELEASE && kvalid && sidx < 6'(SLOTS)) || op == OP_SCAN;

  // counters, quiesce state and the result status once the walk is over
  logic [3:0] fin_status;
  logic [1:0] fin_lock;
  logic       fin_grant, kcnt_up, kcnt_down, total_up, total_down, q_start, q_stop;
  always_comb begin
    fin_status = ST_BAD_ARG;
    fin_lock = LOCK_NONE;
    fin_grant = 1'b0;
    kcnt_up = 1'b0;
    kcnt_down = 1'b0;
    total_up = 1'b0;
    total_down = 1'b0;
    q_start = 1'b0;
    q_stop = 1'b0;
    case (op)
      OP_ACQUIRE: if (!kvalid) fin_status = ST_BAD_ARG;
        else if (qflag) fin_status = ST_QUIESCING;
        else if (!done) fin_status = ST_FULL;
        else begin
          fin_status = ST_OK;
          fin_grant = 1'b1;
          kcnt_up = 1'b1;
          total_up = 1'b1;
          if (total == '0) fin_lock = LOCK_TAKE;
        end
      OP_RELEASE: if (!kvalid || sidx >= 6'(SLOTS)) fin_status = ST_BAD_ARG;
        else if (!done) fin_status = ST_STALE;
        else if (kcnt[kind] == '0) fin_status = ST_UNDERFLOW;
        else begin
          kcnt_down = 1'b1;
          if (total == '0) fin_status = ST_UNDERFLOW;
          else begin
            fin_status = ST_OK;
            total_down = 1'b1;
            if (total == CNT_W'(1)) fin_lock = LOCK_DROP;
          end
        end
      OP_TRY_Q: if (gen == '0) fin_status = ST_BAD_ARG;
        else if (!qflag && total == '0) begin
          q_start = 1'b1;
          fin_status = ST_OK;
        end else begin
          fin_status = ST_NOT_START;
          if (!qflag || qgen == gen) q_stop = 1'b1;
        end
      OP_EMERG_Q: if (gen == '0) fin_status = ST_BAD_ARG;
        else if (!qflag) begin
          q_start = 1'b1;
          fin_status = ST_OK;
        end else fin_status = (qgen == gen) ? ST_OK : ST_NOT_START;
      OP_CANCEL_Q: if (gen != '0 && qgen == gen) begin
          q_stop = 1'b1;
          fin_status = ST_OK;
        end else fin_status = ST_CANCEL_IGN;
      OP_SCAN: fin_status = ST_NO_WARN;
      default: fin_status = ST_BAD_ARG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      next_id <= 32'd1;
      total <= '0;
      qflag <= 1'b0;
      qgen <= '0;
      for (int k = 0; k < KINDS; k++) kcnt[k] <= '0;
      ov <= 1'b0;
      step <= '0;
      done <= 1'b0;
      any_warn <= 1'b0;
    end else begin
      state <= state_next;
      if (push_warn || push_final) ov <= 1'b1;
      else if (!out_stall) ov <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) begin
          op <= opcode; kind <= blocker_id; sidx <= slot_index; tag <= lease_tag;
          gen <= generation_tag; now <= now_time[TIME_BITS-1:0];
          step <= '0; done <= 1'b0; any_warn <= 1'b0;
          grant_slot <= '0; grant_id <= '0;
        end
        S_WALK: if (shift) begin
          step <= step + 1'b1;
          if (walk_ops && acq_hit) begin
            done <= 1'b1;
            next_id <= id_a;
            grant_slot <= step[SLOT_W-1:0];
            grant_id <= id_use;
          end
          if (walk_ops && rel_hit) begin
            done <= 1'b1;
          end
          if (scan_emit) begin
            any_warn <= 1'b1;
            w_slot <= step[SLOT_W-1:0]; w_kind <= head.kind; w_held <= held;
            if (any_warn) begin
              o_status <= ST_WARNING; o_slot <= w_slot; o_gid <= '0;
              o_total <= total; o_kcnt <= kvalid ? kcnt[kind] : '0;
              o_q <= qflag; o_gen <= qgen; o_lock <= LOCK_NONE;
              o_wkind <= w_kind; o_held <= 48'(w_held); o_last <= 1'b0;
            end
          end
        end
        S_FIN: begin
          r_status <= fin_status;
          r_slot <= fin_grant ? grant_slot : '0;
          r_gid <= fin_grant ? grant_id : '0;
          r_lock <= fin_lock;
          if (kcnt_up) kcnt[kind] <= kcnt[kind] + 1'b1;
          else if (kcnt_down) kcnt[kind] <= kcnt[kind] - 1'b1;
          if (total_up) total <= total + 1'b1;
          else if (total_down) total <= total - 1'b1;
          if (q_start) begin
            qflag <= 1'b1; qgen <= gen;
          end else if (q_stop) begin
            qflag <= 1'b0; qgen <= '0;
          end
        end
        S_OUT: if (out_free) begin
          // a scan with warnings sends its staged warning as the final word
          if (op == OP_SCAN && any_warn) begin
            o_status <= ST_WARNING; o_slot <= w_slot; o_gid <= '0; o_lock <= LOCK_NONE;
            o_wkind <= w_kind; o_held <= 48'(w_held);
          end else begin
            o_status <= r_status; o_slot <= r_slot; o_gid <= r_gid; o_lock <= r_lock;
            o_wkind <= '0; o_held <= '0;
          end
          o_last <= 1'b1;
          o_total <= total; o_kcnt <= kvalid ? kcnt[kind] : '0;
          o_q <= qflag; o_gen <= qgen;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov;
  assign status = o_status;
  assign result_slot = o_slot;
  assign granted_id = o_gid;
  assign total_count = o_total;
  assign kind_count = o_kcnt;
  assign quiescing = o_q;
  assign current_generation = o_gen;
  assign sleep_lock_change = o_lock;
  assign warn_blocker = o_wkind;
  assign held_time = o_held;
  assign last = o_last;

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("input taken while busy");
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(SLOTS)) else $error("lease total above slot count");
  a_gen_flag: assert property (@(posedge clk) disable iff (rst)
    !qflag |-> qgen == '0) else $error("generation without quiesce");
endmodule
